@@ rtl/crng_pkg.sv @@
package crng_pkg;

  localparam int TABLE_SIZE_DEF = 32;

  localparam logic [30:0] M1            = 31'd2147483563;
  localparam logic [30:0] M1_LESS_ONE   = 31'd2147483562;
  localparam logic [30:0] M2            = 31'd2147483399;
  localparam logic [15:0] A1            = 16'd40014;
  localparam logic [15:0] A2            = 16'd40692;
  // 2^31 minus each modulus, for folding the high part of the product
  localparam logic [7:0]  C1            = 8'd85;
  localparam logic [7:0]  C2            = 8'd249;
  localparam logic [30:0] GEN_TWO_RESET = 31'd123456789;

  typedef enum logic [0:0] {
    GEN_ONE,
    GEN_TWO
  } gen_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_W_MUL,
    S_W_FOLD,
    S_W_RED,
    S_G1_MUL,
    S_G1_FOLD,
    S_G1_RED,
    S_G2_MUL,
    S_G2_FOLD,
    S_G2_RED,
    S_TAB_RD,
    S_COMB
  } state_t;

  typedef struct packed {
    logic     seed_load;
    gen_sel_t sel;
    logic     warm_wr;
    logic     g1_wr;
    logic     g2_wr;
    logic     div_start;
    logic     tab_rd;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } dp_sts_t;

endpackage

@@ rtl/crng_mm.sv @@
module crng_mm (
  input  logic               clk,
  input  crng_pkg::gen_sel_t sel,
  input  logic [30:0]        x,
  output logic [30:0]        res
);
  import crng_pkg::*;

  logic [15:0] a;
  logic [46:0] prod_r;
  gen_sel_t    sel_p1_r;
  gen_sel_t    sel_p2_r;
  logic [7:0]  c_p1;
  logic [23:0] fold_hi;
  logic [31:0] sum_nxt;
  logic [31:0] sum_r;
  logic [30:0] m_p2;
  logic [31:0] sum_sub;

  assign a = (sel == GEN_TWO) ? A2 : A1;

  // product, then fold of the high part, then final reduction
  assign c_p1    = (sel_p1_r == GEN_TWO) ? C2 : C1;
  assign fold_hi = {8'd0, prod_r[46:31]} * {16'd0, c_p1};
  assign sum_nxt = {8'd0, fold_hi} + {1'b0, prod_r[30:0]};

  assign m_p2    = (sel_p2_r == GEN_TWO) ? M2 : M1;
  assign sum_sub = sum_r - {1'b0, m_p2};
  assign res     = (sum_r >= {1'b0, m_p2}) ? sum_sub[30:0] : sum_r[30:0];

  always_ff @(posedge clk) begin
    prod_r   <= {16'd0, x} * {31'd0, a};
    sel_p1_r <= sel;
    sum_r    <= sum_nxt;
    sel_p2_r <= sel_p1_r;
  end

endmodule

@@ rtl/crng_dp.sv @@
module crng_dp #(
  parameter int TABLE_SIZE = crng_pkg::TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [30:0]       in_seed,
  input  crng_pkg::dp_cmd_t cmd,
  output crng_pkg::dp_sts_t sts,
  output logic [30:0]       out_deviate
);
  import crng_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 8);
  localparam logic [31:0] SLOT_DIV = 32'(64'(M1_LESS_ONE) / 64'(TABLE_SIZE) + 64'd1);

  logic [30:0]   g1_r;
  logic [30:0]   g2_r;
  logic [30:0]   last_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] q_r;
  logic [30:0]   mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  logic [30:0]   rd_data_r;
  logic          rd_vld_r;
  logic [30:0]   out_deviate_r;

  logic [30:0]   seed_nz;
  logic [30:0]   mm_x;
  logic [30:0]   mm_res;
  logic [AW-1:0] slot_q;
  logic [AW-1:0] j;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [30:0]   wr_data;
  logic [30:0]   t;
  logic [32:0]   diff;
  logic [32:0]   diff_wrap;
  logic [30:0]   dev;

  assign seed_nz = (in_seed == 31'd0) ? 31'd1 : in_seed;
  assign mm_x    = (cmd.sel == GEN_TWO) ? g2_r : g1_r;

  crng_mm u_mm (
    .clk (clk),
    .sel (cmd.sel),
    .x   (mm_x),
    .res (mm_res)
  );

  // slot index from the slot boundary compares
  always_comb begin
    slot_q = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if ({1'b0, last_r} >= 32'(k) * SLOT_DIV) begin
        slot_q = AW'(k);
      end
    end
  end

  assign j       = (q_r > AW'(TABLE_SIZE - 1)) ? AW'(TABLE_SIZE - 1) : q_r;

  assign wr_en   = (cmd.warm_wr && (cnt_r < CW'(TABLE_SIZE))) || cmd.finish;
  assign wr_addr = cmd.finish ? j : cnt_r[AW-1:0];
  assign wr_data = cmd.finish ? g1_r : mm_res;

  // untouched slot reads as zero
  assign t         = rd_vld_r ? rd_data_r : 31'd0;
  assign diff      = {2'b00, t} - {2'b00, g2_r};
  assign diff_wrap = diff + {2'b00, M1_LESS_ONE};
  assign dev       = (diff[32] || (diff == 33'd0)) ? diff_wrap[30:0] : diff[30:0];

  assign sts.cnt_zero = (cnt_r == '0);
  assign out_deviate  = out_deviate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r   <= 31'd1;
      g2_r   <= GEN_TWO_RESET;
      last_r <= 31'd0;
      cnt_r  <= '0;
      vld_r  <= '0;
    end else begin
      if (cmd.seed_load) begin
        g1_r  <= seed_nz;
        g2_r  <= seed_nz;
        cnt_r <= CW'(TABLE_SIZE + 7);
      end else begin
        if (cmd.warm_wr || cmd.g1_wr) begin
          g1_r <= mm_res;
        end
        if (cmd.g2_wr) begin
          g2_r <= mm_res;
        end
        if (cmd.warm_wr) begin
          if (cnt_r == '0) begin
            last_r <= mm_res;
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
        end
      end
      if (cmd.finish) begin
        last_r <= dev;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r <= slot_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.tab_rd) begin
      rd_data_r <= mem[j];
      rd_vld_r  <= vld_r[j];
    end
    if (cmd.finish) begin
      out_deviate_r <= dev;
    end
  end

endmodule

@@ rtl/crng_ctrl.sv @@
module crng_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output crng_pkg::dp_cmd_t cmd,
  input  crng_pkg::dp_sts_t sts
);
  import crng_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = GEN_ONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd) begin
            cmd.seed_load = 1'b1;
            state_nxt     = S_W_MUL;
          end else begin
            state_nxt = S_G1_MUL;
          end
        end
      end
      S_W_MUL:  state_nxt = S_W_FOLD;
      S_W_FOLD: state_nxt = S_W_RED;
      S_W_RED: begin
        cmd.warm_wr = 1'b1;
        state_nxt   = sts.cnt_zero ? S_G1_MUL : S_W_MUL;
      end
      S_G1_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_G1_FOLD;
      end
      S_G1_FOLD: state_nxt = S_G1_RED;
      S_G1_RED: begin
        cmd.g1_wr = 1'b1;
        state_nxt = S_G2_MUL;
      end
      S_G2_MUL: begin
        cmd.sel   = GEN_TWO;
        state_nxt = S_G2_FOLD;
      end
      S_G2_FOLD: begin
        cmd.sel   = GEN_TWO;
        state_nxt = S_G2_RED;
      end
      S_G2_RED: begin
        cmd.sel   = GEN_TWO;
        cmd.g2_wr = 1'b1;
        state_nxt = S_TAB_RD;
      end
      S_TAB_RD: begin
        cmd.tab_rd = 1'b1;
        state_nxt  = S_COMB;
      end
      S_COMB: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

endmodule

@@ rtl/combined_lcg_shuffle_rng.sv @@
// channel  dir  signals                                transaction
// in       in   in_valid in_stall in_cmd in_seed[30:0]  one next or reseed command
// out      out  out_valid out_stall out_deviate[30:0]   one combined deviate
//
// next command: the shared modular multiplier runs once per generator (multiply,
// fold, reduce), followed by the table read and the combine step
// reseed command: warm-up multiplier runs on generator one fill the table first
// reset: generators at 1 and 123456789, table valid bits cleared, no clear pass
// input is stalled while a transaction is in work; it completes only once the
// output register is free or being taken
module combined_lcg_shuffle_rng #(
  parameter int TABLE_SIZE = crng_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [30:0] in_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_deviate
);
  import crng_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  crng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  crng_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_seed     (in_seed),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .out_deviate (out_deviate)
  );

`ifndef SYNTHESIS
  a_acc_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after acceptance");

  a_dev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_deviate != 31'd0) && (out_deviate < M1)))
    else $error("deviate out of range");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in work");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.finish |=> (out_valid && !in_stall))
    else $error("finished transaction not presented");
`endif

endmodule

@@ bench/tb_combined_lcg_shuffle_rng.sv @@
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_rng;

  localparam longint MOD1     = 64'd2147483563;
  localparam longint MUL1     = 64'd40014;
  localparam longint MOD2     = 64'd2147483399;
  localparam longint MUL2     = 64'd40692;
  localparam int     TAB_N    = crng_pkg::TABLE_SIZE_DEF;
  localparam longint SLOT_DIV = 1 + (MOD1 - 1) / TAB_N;
  localparam int     N_DIR    = 21;
  localparam int     N_RAND   = 1050;

  typedef struct packed {
    logic        cmd;
    logic [30:0] seed;
    logic        typed;
    logic [30:0] dev;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    {1'b0, 31'd0,          1'b1, 31'd1407495835},
    {1'b0, 31'h7fffffff,   1'b0, 31'd0},
    {1'b0, 31'd0,          1'b0, 31'd0},
    {1'b1, 31'd0,          1'b0, 31'd0},
    {1'b0, 31'd0,          1'b0, 31'd0},
    {1'b1, 31'd1,          1'b0, 31'd0},
    {1'b0, 31'h2aaaaaaa,   1'b0, 31'd0},
    {1'b1, 31'h7fffffff,   1'b0, 31'd0},
    {1'b0, 31'd0,          1'b0, 31'd0},
    {1'b1, 31'd2147483563, 1'b0, 31'd0},
    {1'b0, 31'd0,          1'b0, 31'd0},
    {1'b0, 31'h55555555,   1'b0, 31'd0},
    {1'b1, 31'd2147483399, 1'b0, 31'd0},
    {1'b0, 31'd0,          1'b0, 31'd0},
    {1'b1, 31'd2147483562, 1'b0, 31'd0},
    {1'b1, 31'd2147483398, 1'b0, 31'd0},
    {1'b1, 31'd123456789,  1'b0, 31'd0},
    {1'b0, 31'd0,          1'b0, 31'd0},
    {1'b1, 31'h55555555,   1'b0, 31'd0},
    {1'b1, 31'h2aaaaaaa,   1'b0, 31'd0},
    {1'b0, 31'd0,          1'b0, 31'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [30:0] in_seed = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] out_deviate;

  logic        row_typed = 1'b0;
  logic [30:0] row_dev = '0;
  logic        calm = 1'b0;
  int          stall_left = 0;

  longint      gen1 = 1;
  longint      gen2 = 64'd123456789;
  longint      prev_dev = 0;
  longint      shuffle [TAB_N];

  logic [30:0] deviate_q [$];
  int          errors = 0;
  int          n_next = 0;
  int          n_reseed = 0;
  int          n_checked = 0;

  combined_lcg_shuffle_rng dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_seed     (in_seed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_deviate (out_deviate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint mul_mod(longint x, longint a, longint m);
    return (a * x) % m;
  endfunction

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [30:0] advance_deviate(logic cmd, logic [30:0] seed);
    longint s;
    longint d;
    int     slot;
    int     i;
    if (cmd) begin
      s = (seed == 0) ? 1 : longint'(seed);
      gen1 = s;
      gen2 = s;
      for (i = TAB_N + 7; i >= 0; i--) begin
        gen1 = mul_mod(gen1, MUL1, MOD1);
        if (i < TAB_N) shuffle[i] = gen1;
      end
      prev_dev = shuffle[0];
    end
    gen1 = mul_mod(gen1, MUL1, MOD1);
    gen2 = mul_mod(gen2, MUL2, MOD2);
    slot = int'(prev_dev / SLOT_DIV);
    if (slot < 0) slot = 0;
    if (slot >= TAB_N) slot = TAB_N - 1;
    d = shuffle[slot] - gen2;
    shuffle[slot] = gen1;
    if (d < 1) d += MOD1 - 1;
    prev_dev = d;
    return d[30:0];
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= pick_idle_len();
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(6);
    end
  end

  always @(posedge clk) begin : scoreboard
    logic [30:0] predicted;
    logic [30:0] want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = advance_deviate(in_cmd, in_seed);
        deviate_q.push_back(row_typed ? row_dev : predicted);
        if (in_cmd) n_reseed++;
        else n_next++;
      end
      if (out_valid && !out_stall) begin
        n_checked++;
        if (deviate_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected deviate %0d", out_deviate);
        end else begin
          want = deviate_q.pop_front();
          if (out_deviate !== want) begin
            errors++;
            if (errors <= 10)
              $display("deviate mismatch: expected %0d actual %0d", want, out_deviate);
          end
        end
      end
    end
  end

  initial begin : driver
    stim_row_t row;
    int        k;
    int        gap;
    for (k = 0; k < TAB_N; k++) shuffle[k] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (k = 0; k < N_DIR + N_RAND; k++) begin
      if (k < N_DIR) begin
        row = DIR_ROWS[k];
      end else begin
        row.cmd = ($urandom_range(99) < 12);
        row.seed = 31'($urandom);
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(5))
            0: row.seed = 31'd0;
            1: row.seed = 31'd1;
            2: row.seed = 31'd2147483563;
            3: row.seed = 31'd2147483399;
            4: row.seed = 31'h7fffffff;
            default: row.seed = 31'd2147483562;
          endcase
        end
        row.typed = 1'b0;
        row.dev = '0;
      end
      calm <= (k >= N_DIR + 300 && k < N_DIR + 450);
      // drain everything before carrying on
      if (k == N_DIR + 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (deviate_q.size() != 0) @(posedge clk);
      end
      gap = (k >= N_DIR + 300 && k < N_DIR + 450) ? 0 : pick_idle_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_cmd <= row.cmd;
      in_seed <= row.seed;
      row_typed <= row.typed;
      row_dev <= row.dev;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
    calm <= 1'b0;
    while (deviate_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("ran %0d next and %0d reseed transactions, %0d deviates compared",
             n_next, n_reseed, n_checked);
    $display("%0d mismatches, %0d deviates still outstanding", errors, deviate_q.size());
    if (errors == 0 && deviate_q.size() == 0) begin
      $display("tb_combined_lcg_shuffle_rng OK");
    end else begin
      $display("tb_combined_lcg_shuffle_rng NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("tb_combined_lcg_shuffle_rng NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/crng_pkg.sv
rtl/crng_mm.sv
rtl/crng_dp.sv
rtl/crng_ctrl.sv
rtl/combined_lcg_shuffle_rng.sv
bench/tb_combined_lcg_shuffle_rng.sv
